// ===== src/mcac_pkg.sv =====
// Shared types and constants for the memory pattern checker.
package mcac_pkg;

  localparam int OP_W     = 2;
  localparam int OFF_W    = 37;
  localparam int WORD_W   = 64;
  localparam int RIDX_W   = 8;
  localparam int CNT_W    = 40;
  localparam int BKT_W    = 28;
  localparam int SNUM_W   = 9;
  localparam int WIN_W    = 9;
  localparam int HITS_W   = 6;
  localparam int BKT_AW   = 10;
  localparam int BLIM_W   = 8;

  localparam logic [OP_W-1:0] OP_GEN   = 2'd0;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  // register select is byte address bit 2
  localparam logic REG_HIGH_MODE    = 1'b0;
  localparam logic REG_BUCKET_LIMIT = 1'b1;

  localparam logic [WORD_W-1:0] GOLDEN  = 64'h9E3779B97F4A7C15;
  localparam logic [31:0]       GOLD_LO = GOLDEN[31:0];
  localparam logic [31:0]       GOLD_HI = GOLDEN[63:32];
  localparam logic [WORD_W-1:0] MARK    = 64'h8000000000000000;

  localparam int GIB_SHIFT   = 30;
  localparam int ALIAS_SHIFT = 35;   // 32 GiB
  localparam int MOD4_BITS   = 32;   // 4 GiB
  // (x +/- 32 GiB) * GOLDEN differs from x * GOLDEN by this step
  localparam logic [WORD_W-1:0] ALIAS_STEP = GOLDEN << ALIAS_SHIFT;
  // (x +/- 32 GiB) >> 3 differs from x >> 3 by this step
  localparam logic [WORD_W-1:0] SHIFT_STEP = 64'd1 << (ALIAS_SHIFT - 3);

  localparam int NUM_CNT       = 8;   // total, six hypotheses, other
  localparam int FIRST_BKT_IDX = 8;
  localparam int FIRST_SAMPLES = 5;
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_AW       = 3;

  typedef struct packed {
    logic [WORD_W-1:0] expected_word;
    logic              mismatch;
    logic [HITS_W-1:0] hypothesis_hits;
    logic              unmatched;
    logic              sample_taken;
    logic [SNUM_W-1:0] sample_number;
    logic [CNT_W-1:0]  counter_value;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic              clr;
    logic [BKT_AW-1:0] addr;
    logic [BKT_W-1:0]  data;
  } bkt_cmd_t;

endpackage

// ===== src/mcac_if.sv =====
// Valid/ready channel interfaces for input and result items.
interface mcac_in_if;
  logic                         valid;
  logic                         ready;
  logic [mcac_pkg::OP_W-1:0]    op;
  logic [mcac_pkg::OFF_W-1:0]   offset;
  logic [mcac_pkg::WORD_W-1:0]  actual_word;
  logic [mcac_pkg::RIDX_W-1:0]  read_index;

  modport source (output valid, op, offset, actual_word, read_index, input ready);
  modport sink (input valid, op, offset, actual_word, read_index, output ready);
endinterface

interface mcac_out_if;
  logic                         valid;
  logic                         ready;
  logic [mcac_pkg::WORD_W-1:0]  expected_word;
  logic                         mismatch;
  logic [mcac_pkg::HITS_W-1:0]  hypothesis_hits;
  logic                         unmatched;
  logic                         sample_taken;
  logic [mcac_pkg::SNUM_W-1:0]  sample_number;
  logic [mcac_pkg::CNT_W-1:0]   counter_value;

  modport source (output valid, expected_word, mismatch, hypothesis_hits, unmatched,
                  sample_taken, sample_number, counter_value, input ready);
  modport sink (input valid, expected_word, mismatch, hypothesis_hits, unmatched,
                sample_taken, sample_number, counter_value, output ready);
endinterface

// ===== src/mcac_pat.sv =====
// Three-stage pattern generator: expected word and the three alias words.
module mcac_pat (
  input  logic                          clk,
  input  logic [mcac_pkg::OFF_W-1:0]    off_i,
  output logic [mcac_pkg::WORD_W-1:0]   exp_o,
  output logic [mcac_pkg::WORD_W-1:0]   minus_o,
  output logic [mcac_pkg::WORD_W-1:0]   plus_o,
  output logic [mcac_pkg::WORD_W-1:0]   mod4_o
);

  logic [63:0] pa_nxt, pa_r;
  logic [31:0] pb_nxt, pb_r, pc_nxt, pc_r;
  logic [mcac_pkg::OFF_W-1:0] off1_r, off2_r;
  logic [31:0] hi_sum;
  logic [63:0] pf_nxt, pf_r, pl_nxt, pl_r;
  logic [63:0] sh, sh_lo;
  logic [63:0] exp_nxt, minus_nxt, plus_nxt, mod4_nxt;

  // partial products of offset * GOLDEN, kept to 64 bits
  assign pa_nxt = off_i[31:0] * mcac_pkg::GOLD_LO;
  assign pb_nxt = 32'(off_i[31:0] * mcac_pkg::GOLD_HI);
  assign pc_nxt = 32'(off_i[mcac_pkg::OFF_W-1:32] * mcac_pkg::GOLD_LO);

  assign hi_sum = pb_r + pc_r;
  assign pf_nxt = pa_r + {hi_sum, 32'b0};
  assign pl_nxt = pa_r + {pb_r, 32'b0};

  assign sh    = 64'(off2_r >> 3);
  assign sh_lo = 64'(off2_r[mcac_pkg::MOD4_BITS-1:0] >> 3);

  always_comb begin
    exp_nxt  = pf_r ^ sh;
    mod4_nxt = pl_r ^ sh_lo;
    plus_nxt = (pf_r + mcac_pkg::ALIAS_STEP) ^ (sh + mcac_pkg::SHIFT_STEP);
    if (off2_r[mcac_pkg::OFF_W-1:mcac_pkg::ALIAS_SHIFT] != '0) begin
      minus_nxt = (pf_r - mcac_pkg::ALIAS_STEP) ^ (sh - mcac_pkg::SHIFT_STEP);
    end else begin
      minus_nxt = '1;
    end
  end

  always_ff @(posedge clk) begin
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    pc_r    <= pc_nxt;
    off1_r  <= off_i;
    pf_r    <= pf_nxt;
    pl_r    <= pl_nxt;
    off2_r  <= off1_r;
    exp_o   <= exp_nxt;
    minus_o <= minus_nxt;
    plus_o  <= plus_nxt;
    mod4_o  <= mod4_nxt;
  end

endmodule

// ===== src/mcac_bkt.sv =====
// Bucket counter memory: synchronous read, valid bits, write-to-read bypass.
module mcac_bkt #(
  parameter int MAX_BUCKETS = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [mcac_pkg::BKT_AW-1:0]  rd_addr,
  input  mcac_pkg::bkt_cmd_t           cmd,
  output logic [mcac_pkg::BKT_W-1:0]   rd_data
);

  localparam int AW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int DEPTH = 2 ** AW;

  logic [mcac_pkg::BKT_W-1:0] mem [DEPTH];
  logic [mcac_pkg::BKT_W-1:0] rd_q, byp_d_r;
  logic [AW-1:0]              raddr_q;
  logic [DEPTH-1:0]           vld_r, vld_nxt;
  logic                       byp_v_r, byp_v_nxt;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.addr[AW-1:0]] <= cmd.data;
    end
    rd_q    <= mem[rd_addr[AW-1:0]];
    raddr_q <= rd_addr[AW-1:0];
    byp_d_r <= cmd.data;
  end

  always_comb begin
    vld_nxt = vld_r;
    if (cmd.clr) begin
      vld_nxt = '0;
    end else if (cmd.we) begin
      vld_nxt[cmd.addr[AW-1:0]] = 1'b1;
    end
    byp_v_nxt = cmd.we && (cmd.addr[AW-1:0] == rd_addr[AW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      byp_v_r <= 1'b0;
    end else begin
      vld_r   <= vld_nxt;
      byp_v_r <= byp_v_nxt;
    end
  end

  assign rd_data = byp_v_r ? byp_d_r : (vld_r[raddr_q] ? rd_q : '0);

endmodule

// ===== src/mcac_fifo.sv =====
// Result item queue between the checker pipeline and the output channel.
module mcac_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mcac_pkg::out_item_t  push_item,
  input  logic                 pop,
  output logic                 head_valid,
  output mcac_pkg::out_item_t  head_item
);

  mcac_pkg::out_item_t mem [mcac_pkg::FIFO_DEPTH];
  logic [mcac_pkg::FIFO_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [mcac_pkg::FIFO_AW:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_item;
    end
  end

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (mcac_pkg::FIFO_AW+1)'(push) - (mcac_pkg::FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_item  = mem[rp_r];

endmodule

// ===== src/memory_pattern_checker_alias_classify.sv =====
// Top level: memory test pattern checker with alias classification.
//
//   port group   dir      kind            content
//   in_chan      sink     valid/ready     op, offset, actual_word, read_index
//   out_chan     source   valid/ready     expected word, check flags, sample, counter
//   p*           slave    APB write/read  high_mode @0x0, bucket_limit @0x4
//
// One item per cycle sustained while in_chan.ready is high; a result is offered once its item
// has passed the pipeline and been pushed into the result queue. The pipeline depth comes from
// the two-level partial-product multiply and the bucket memory's read-modify-write, both
// pipelined; the result queue holds 8 items. Synchronous active-low reset clears all
// counters, bucket valid bits and the queue. Output stalls back up into in_chan.ready once 8 items are outstanding.
module memory_pattern_checker_alias_classify #(
  parameter int MAX_BUCKETS  = 128,
  parameter int SAMPLE_LIMIT = 400,
  parameter int WINDOW_SHIFT = 28
) (
  input  logic         clk,
  input  logic         rst_n,
  mcac_in_if.sink      in_chan,
  mcac_out_if.source   out_chan,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int SW = $clog2(SAMPLE_LIMIT + 1);
  localparam int IW = 12;

  typedef struct packed {
    logic [mcac_pkg::OP_W-1:0]   op;
    logic [mcac_pkg::WORD_W-1:0] actual;
    logic [mcac_pkg::RIDX_W-1:0] ridx;
    logic [mcac_pkg::BKT_AW-1:0] addr;
    logic                        bkt_ok;
    logic                        rd_bkt;
    logic [mcac_pkg::WIN_W-1:0]  win;
  } ctl_t;

  // configuration
  logic                          high_mode_r;
  logic [mcac_pkg::BLIM_W-1:0]   bucket_limit_r;
  logic                          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_mode_r    <= 1'b0;
      bucket_limit_r <= '0;
    end else if (cfg_we) begin
      if (paddr[2] == mcac_pkg::REG_HIGH_MODE) begin
        high_mode_r <= pwdata[0];
      end else begin
        bucket_limit_r <= pwdata[mcac_pkg::BLIM_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == mcac_pkg::REG_BUCKET_LIMIT) ? 32'(bucket_limit_r)
                                                           : 32'(high_mode_r);

  // input side
  logic                 acc, pop;
  logic [mcac_pkg::FIFO_AW:0] used_r, used_nxt;
  logic [6:0]           bucket;
  logic [IW-1:0]        ridx_w, bkt_idx;
  ctl_t                 c0, c1_r, c2_r, c3_r;
  logic                 v1_r, v2_r, v3_r;

  assign in_chan.ready = (used_r < (mcac_pkg::FIFO_AW+1)'(mcac_pkg::FIFO_DEPTH));
  assign acc = in_chan.valid && in_chan.ready;
  assign pop = out_chan.valid && out_chan.ready;
  assign used_nxt = used_r + (mcac_pkg::FIFO_AW+1)'(acc) - (mcac_pkg::FIFO_AW+1)'(pop);

  assign bucket  = in_chan.offset[mcac_pkg::OFF_W-1:mcac_pkg::GIB_SHIFT];
  assign ridx_w  = IW'(in_chan.read_index);
  assign bkt_idx = ridx_w - IW'(mcac_pkg::FIRST_BKT_IDX);

  always_comb begin
    c0.op     = in_chan.op;
    c0.actual = in_chan.actual_word;
    c0.ridx   = in_chan.read_index;
    c0.win    = mcac_pkg::WIN_W'(in_chan.offset >> WINDOW_SHIFT);
    c0.bkt_ok = (mcac_pkg::BLIM_W'(bucket) < bucket_limit_r) &&
                (IW'(bucket) < IW'(MAX_BUCKETS));
    c0.rd_bkt = (in_chan.op == mcac_pkg::OP_READ) &&
                (ridx_w >= IW'(mcac_pkg::FIRST_BKT_IDX)) &&
                (ridx_w < IW'(mcac_pkg::FIRST_BKT_IDX + MAX_BUCKETS));
    c0.addr   = (in_chan.op == mcac_pkg::OP_READ) ? mcac_pkg::BKT_AW'(bkt_idx)
                                                  : mcac_pkg::BKT_AW'(bucket);
  end

  always_ff @(posedge clk) begin
    c1_r <= c0;
    c2_r <= c1_r;
    c3_r <= c2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      used_r <= '0;
    end else begin
      v1_r   <= acc;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      used_r <= used_nxt;
    end
  end

  // pattern words
  logic [mcac_pkg::WORD_W-1:0] pat_exp, pat_minus, pat_plus, pat_mod4;

  mcac_pat u_pat (
    .clk     (clk),
    .off_i   (in_chan.offset),
    .exp_o   (pat_exp),
    .minus_o (pat_minus),
    .plus_o  (pat_plus),
    .mod4_o  (pat_mod4)
  );

  // bucket memory
  mcac_pkg::bkt_cmd_t           bkt_cmd;
  logic [mcac_pkg::BKT_W-1:0]   bkt_rd;

  mcac_bkt #(.MAX_BUCKETS(MAX_BUCKETS)) u_bkt (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (c2_r.addr),
    .cmd     (bkt_cmd),
    .rd_data (bkt_rd)
  );

  // final stage: classify, count, sample
  logic [mcac_pkg::CNT_W-1:0]  cnt_r [mcac_pkg::NUM_CNT];
  logic [mcac_pkg::CNT_W-1:0]  cnt_nxt [mcac_pkg::NUM_CNT];
  logic [SW-1:0]               st_r, st_nxt;
  logic [mcac_pkg::WIN_W-1:0]  lw_r, lw_nxt;
  logic [mcac_pkg::WORD_W-1:0] exp_w;
  logic                        is_clr, mism, unm, take;
  logic [mcac_pkg::HITS_W-1:0] hits;
  logic [mcac_pkg::NUM_CNT-1:0] inc;
  mcac_pkg::out_item_t         res;

  assign exp_w  = pat_exp | (high_mode_r ? mcac_pkg::MARK : '0);
  assign is_clr = v3_r && (c3_r.op == mcac_pkg::OP_CLEAR);
  assign mism   = v3_r && (c3_r.op == mcac_pkg::OP_CHECK) && (c3_r.actual != exp_w);

  always_comb begin
    hits[0] = c3_r.actual == pat_minus;
    hits[1] = c3_r.actual == (pat_minus | mcac_pkg::MARK);
    hits[2] = c3_r.actual == pat_plus;
    hits[3] = c3_r.actual == (pat_plus | mcac_pkg::MARK);
    hits[4] = c3_r.actual == pat_mod4;
    hits[5] = c3_r.actual == (pat_mod4 | mcac_pkg::MARK);
    if (!mism) begin
      hits = '0;
    end
  end

  assign unm  = mism && (hits == '0);
  assign inc  = {unm, hits, mism};
  assign take = mism && ((st_r < SW'(mcac_pkg::FIRST_SAMPLES)) ||
                         ((c3_r.win != lw_r) && (st_r < SW'(SAMPLE_LIMIT))));

  always_comb begin
    for (int i = 0; i < mcac_pkg::NUM_CNT; i++) begin
      cnt_nxt[i] = is_clr ? '0 : cnt_r[i] + mcac_pkg::CNT_W'(inc[i]);
    end
    st_nxt = st_r;
    lw_nxt = lw_r;
    if (is_clr) begin
      st_nxt = '0;
      lw_nxt = '0;
    end else if (take) begin
      st_nxt = st_r + 1'b1;
      lw_nxt = c3_r.win;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mcac_pkg::NUM_CNT; i++) begin
        cnt_r[i] <= '0;
      end
      st_r <= '0;
      lw_r <= '0;
    end else begin
      for (int i = 0; i < mcac_pkg::NUM_CNT; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      st_r <= st_nxt;
      lw_r <= lw_nxt;
    end
  end

  always_comb begin
    bkt_cmd.we   = mism && c3_r.bkt_ok;
    bkt_cmd.clr  = is_clr;
    bkt_cmd.addr = c3_r.addr;
    bkt_cmd.data = bkt_rd + 1'b1;
  end

  always_comb begin
    res.expected_word   = exp_w;
    res.mismatch        = mism;
    res.hypothesis_hits = hits;
    res.unmatched       = unm;
    res.sample_taken    = take;
    res.sample_number   = take ? mcac_pkg::SNUM_W'(st_r) : '0;
    res.counter_value   = '0;
    if (c3_r.op == mcac_pkg::OP_READ) begin
      priority if (IW'(c3_r.ridx) < IW'(mcac_pkg::NUM_CNT)) begin
        res.counter_value = cnt_r[c3_r.ridx[2:0]];
      end else if (c3_r.rd_bkt) begin
        res.counter_value = mcac_pkg::CNT_W'(bkt_rd);
      end else if (IW'(c3_r.ridx) == IW'(mcac_pkg::FIRST_BKT_IDX + MAX_BUCKETS)) begin
        res.counter_value = mcac_pkg::CNT_W'(st_r);
      end else begin
        res.counter_value = '0;
      end
    end
  end

  // result queue
  logic                head_valid;
  mcac_pkg::out_item_t head_item;

  mcac_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (v3_r),
    .push_item  (res),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  assign out_chan.valid           = head_valid;
  assign out_chan.expected_word   = head_item.expected_word;
  assign out_chan.mismatch        = head_item.mismatch;
  assign out_chan.hypothesis_hits = head_item.hypothesis_hits;
  assign out_chan.unmatched       = head_item.unmatched;
  assign out_chan.sample_taken    = head_item.sample_taken;
  assign out_chan.sample_number   = head_item.sample_number;
  assign out_chan.counter_value   = head_item.counter_value;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the memory pattern checker: directed and random items, scoreboarded.
`timescale 1ns / 1ps

module tb_top;
  import mcac_pkg::*;

  localparam int BUCKETS    = 128;
  localparam int SAMPLE_CAP = 400;
  localparam int WIN_SHIFT  = 28;
  localparam logic [63:0] SPAN_32G = 64'h8_0000_0000;
  localparam logic [36:0] TOP_OFF  = 37'h1F_FFFF_FFFF;

  typedef enum int {
    W_MATCH, W_FLIP, W_MINUS, W_MINUS_MK, W_PLUS, W_PLUS_MK,
    W_MOD4, W_MOD4_MK, W_RANDOM, W_ONES
  } word_kind_t;

  typedef enum int {MIX_CLEAR, MIX_KEEP, SAMPLE_RUN} mix_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [OFF_W-1:0]  offset;
    logic [WORD_W-1:0] actual_word;
    logic [RIDX_W-1:0] read_index;
  } req_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mcac_in_if  in_chan();
  mcac_out_if out_chan();

  memory_pattern_checker_alias_classify #(
    .MAX_BUCKETS (BUCKETS),
    .SAMPLE_LIMIT(SAMPLE_CAP),
    .WINDOW_SHIFT(WIN_SHIFT)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic             cfg_high  = 1'b0;
  logic [7:0]       cfg_limit = 8'd0;
  logic [CNT_W-1:0] bad_total = '0;
  logic [CNT_W-1:0] alias_cnt [7];
  logic [BKT_W-1:0] bucket_cnt [BUCKETS];
  logic [8:0]       sample_cnt  = '0;
  logic [WIN_W-1:0] prev_win = '0;

  req_t       pending [$];
  out_item_t  result_q [$];
  req_t       cur_req;
  logic [OFF_W-1:0] last_off = '0;

  bit idle_on, stall_on, hold_req;
  int gap_left, stall_left;
  int errors, n_items, n_results, n_bad, n_hits, n_samples, n_writes;

  initial begin
    foreach (alias_cnt[i]) alias_cnt[i] = '0;
    foreach (bucket_cnt[i]) bucket_cnt[i] = '0;
  end

  function automatic logic [63:0] pattern_word(input logic [63:0] x);
    return (x * GOLDEN) ^ (x >> 3);
  endfunction

  function automatic out_item_t classify_item(input req_t rq);
    out_item_t   r;
    logic [63:0] off64, w;
    logic [63:0] hw [6];
    int          bkt;
    logic [WIN_W-1:0] win;
    r = '0;
    off64 = {27'd0, rq.offset};
    w = pattern_word(off64) | (cfg_high ? MARK : 64'd0);
    r.expected_word = w;
    case (rq.op)
      OP_CHECK: begin
        if (rq.actual_word != w) begin
          r.mismatch = 1'b1;
          n_bad++;
          bad_total = bad_total + 1'b1;
          bkt = int'(off64 >> GIB_SHIFT);
          if (bkt < int'(cfg_limit) && bkt < BUCKETS)
            bucket_cnt[bkt] = bucket_cnt[bkt] + 1'b1;
          hw[0] = (off64 >= SPAN_32G) ? pattern_word(off64 - SPAN_32G) : '1;
          hw[1] = hw[0] | MARK;
          hw[2] = pattern_word(off64 + SPAN_32G);
          hw[3] = hw[2] | MARK;
          hw[4] = pattern_word({32'd0, off64[31:0]});
          hw[5] = hw[4] | MARK;
          for (int k = 0; k < 6; k++) begin
            if (rq.actual_word == hw[k]) begin
              r.hypothesis_hits[k] = 1'b1;
              alias_cnt[k] = alias_cnt[k] + 1'b1;
              n_hits++;
            end
          end
          if (r.hypothesis_hits == '0) begin
            r.unmatched = 1'b1;
            alias_cnt[6] = alias_cnt[6] + 1'b1;
          end
          win = WIN_W'(off64 >> WIN_SHIFT);
          if (sample_cnt < FIRST_SAMPLES || (win != prev_win && sample_cnt < SAMPLE_CAP)) begin
            prev_win = win;
            r.sample_taken = 1'b1;
            r.sample_number = sample_cnt;
            sample_cnt = sample_cnt + 1'b1;
            n_samples++;
          end
        end
      end
      OP_READ: begin
        if (rq.read_index == 0) r.counter_value = bad_total;
        else if (rq.read_index <= 7) r.counter_value = alias_cnt[rq.read_index - 1];
        else if (rq.read_index < 8 + BUCKETS)
          r.counter_value = CNT_W'(bucket_cnt[rq.read_index - 8]);
        else if (rq.read_index == 8 + BUCKETS) r.counter_value = CNT_W'(sample_cnt);
      end
      OP_CLEAR: begin
        bad_total = '0;
        foreach (alias_cnt[i]) alias_cnt[i] = '0;
        foreach (bucket_cnt[i]) bucket_cnt[i] = '0;
        sample_cnt = '0;
        prev_win = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // readback word of a chosen flavour for this offset under the current mode
  function automatic logic [63:0] readback_word(input logic [OFF_W-1:0] off,
                                                input word_kind_t kind);
    logic [63:0] off64, good, minus, plus, mod4;
    off64 = {27'd0, off};
    good  = pattern_word(off64) | (cfg_high ? MARK : 64'd0);
    minus = (off64 >= SPAN_32G) ? pattern_word(off64 - SPAN_32G) : '1;
    plus  = pattern_word(off64 + SPAN_32G);
    mod4  = pattern_word({32'd0, off64[31:0]});
    case (kind)
      W_MATCH:    return good;
      W_FLIP:     return good ^ (64'd1 << $urandom_range(0, 63));
      W_MINUS:    return minus;
      W_MINUS_MK: return minus | MARK;
      W_PLUS:     return plus;
      W_PLUS_MK:  return plus | MARK;
      W_MOD4:     return mod4;
      W_MOD4_MK:  return mod4 | MARK;
      W_ONES:     return '1;
      default:    return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [OFF_W-1:0] rand_offset();
    logic [63:0] raw;
    logic [OFF_W-1:0] o;
    int r;
    r = $urandom_range(0, 9);
    raw = {$urandom, $urandom};
    o = raw[OFF_W-1:0];
    if (r < 3) o[36:32] = '0;
    else if (r < 6) o[36:35] = '0;
    else if (r >= 8) o = last_off + (OFF_W'($urandom_range(0, 64)) << 3);
    if ($urandom_range(0, 7) != 0) o[2:0] = '0;
    last_off = o;
    return o;
  endfunction

  function automatic req_t make_item(input mix_t style);
    req_t rq;
    int r, k;
    r = $urandom_range(0, 99);
    rq.offset = rand_offset();
    rq.actual_word = {$urandom, $urandom};
    rq.read_index = ($urandom_range(0, 9) < 8) ? RIDX_W'($urandom_range(0, 8 + BUCKETS))
                                               : RIDX_W'($urandom_range(9 + BUCKETS, 255));
    if (style == SAMPLE_RUN) begin
      rq.op = (r < 85) ? OP_CHECK : (r < 93) ? OP_READ : OP_GEN;
      k = $urandom_range(1, 9);
    end else begin
      rq.op = (r < 15) ? OP_GEN : (r < 73) ? OP_CHECK :
              (r < 97 || style == MIX_KEEP) ? OP_READ : OP_CLEAR;
      k = $urandom_range(0, 12);
      if (k > 9) k = 0;
    end
    if (rq.op == OP_CHECK) rq.actual_word = readback_word(rq.offset, word_kind_t'(k));
    return rq;
  endfunction

  function automatic int pause_len(input bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        result_q.push_back(classify_item(cur_req));
        n_items++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur_req = pending.pop_front();
          in_chan.op          <= cur_req.op;
          in_chan.offset      <= cur_req.offset;
          in_chan.actual_word <= cur_req.actual_word;
          in_chan.read_index  <= cur_req.read_index;
          in_chan.valid       <= 1'b1;
          gap_left = pause_len(idle_on);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and scoreboard
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        out_item_t want;
        n_results++;
        if (result_q.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          want = result_q.pop_front();
          if (out_chan.expected_word !== want.expected_word) begin
            $error("expected_word: expected %h, got %h",
                   want.expected_word, out_chan.expected_word);
            errors++;
          end
          if (out_chan.mismatch !== want.mismatch) begin
            $error("mismatch: expected %0d, got %0d", want.mismatch, out_chan.mismatch);
            errors++;
          end
          if (out_chan.hypothesis_hits !== want.hypothesis_hits) begin
            $error("hypothesis_hits: expected %b, got %b",
                   want.hypothesis_hits, out_chan.hypothesis_hits);
            errors++;
          end
          if (out_chan.unmatched !== want.unmatched) begin
            $error("unmatched: expected %0d, got %0d", want.unmatched, out_chan.unmatched);
            errors++;
          end
          if (out_chan.sample_taken !== want.sample_taken) begin
            $error("sample_taken: expected %0d, got %0d",
                   want.sample_taken, out_chan.sample_taken);
            errors++;
          end
          if (out_chan.sample_number !== want.sample_number) begin
            $error("sample_number: expected %0d, got %0d",
                   want.sample_number, out_chan.sample_number);
            errors++;
          end
          if (out_chan.counter_value !== want.counter_value) begin
            $error("counter_value: expected %h, got %h",
                   want.counter_value, out_chan.counter_value);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 200;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        stall_left = pause_len(stall_on);
        out_chan.ready <= (stall_left == 0);
      end
    end
  end

  task automatic reg_write(input logic sel, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_HIGH_MODE) cfg_high = val[0];
    else cfg_limit = val[7:0];
    n_writes++;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending.size() != 0 || in_chan.valid || result_q.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic push_req(input logic [OP_W-1:0] op, input logic [OFF_W-1:0] off,
                          input logic [WORD_W-1:0] word, input logic [RIDX_W-1:0] idx);
    req_t rq;
    rq.op = op;
    rq.offset = off;
    rq.actual_word = word;
    rq.read_index = idx;
    pending.push_back(rq);
  endtask

  task automatic run_phase(input logic hi, input logic [7:0] lim, input bit gaps,
                           input bit stalls, input bit hold, input mix_t style,
                           input int count);
    reg_write(REG_HIGH_MODE, {31'd0, hi});
    reg_write(REG_BUCKET_LIMIT, {24'd0, lim});
    idle_on  = gaps;
    stall_on = stalls;
    for (int i = 0; i < count; i++) pending.push_back(make_item(style));
    if (hold) hold_req = 1'b1;
    drain();
  endtask

  initial begin
    in_chan.valid       = 1'b0;
    in_chan.op          = OP_GEN;
    in_chan.offset      = '0;
    in_chan.actual_word = '0;
    in_chan.read_index  = '0;
    out_chan.ready      = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_n   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, so no bucket is counted
    idle_on  = 1'b1;
    stall_on = 1'b1;
    push_req(OP_GEN, '0, '0, '0);
    push_req(OP_GEN, TOP_OFF, '1, 8'hFF);
    push_req(OP_GEN, 37'h1_2345_6789, '0, '0);
    push_req(OP_CHECK, 37'h1000, readback_word(37'h1000, W_MATCH), '0);
    push_req(OP_CHECK, 37'h2000, '1, '0);
    push_req(OP_CHECK, 37'h8_0000_0000, readback_word(37'h8_0000_0000, W_MINUS), '0);
    push_req(OP_CHECK, 37'h8_0000_0008, readback_word(37'h8_0000_0008, W_MINUS_MK), '0);
    push_req(OP_CHECK, 37'hA_0000_0000, readback_word(37'hA_0000_0000, W_PLUS), '0);
    push_req(OP_CHECK, 37'h1_0000_0040, readback_word(37'h1_0000_0040, W_MOD4), '0);
    push_req(OP_CHECK, 37'h1_4000_0000, readback_word(37'h1_4000_0000, W_MOD4_MK), '0);
    push_req(OP_CHECK, 37'h19_0000_0000, readback_word(37'h19_0000_0000, W_RANDOM), '0);
    push_req(OP_CHECK, 37'h19_0000_0008, readback_word(37'h19_0000_0008, W_FLIP), '0);
    push_req(OP_CHECK, TOP_OFF, readback_word(TOP_OFF, W_PLUS_MK), '0);
    push_req(OP_READ, '0, '0, 8'd0);
    push_req(OP_READ, '0, '0, 8'd1);
    push_req(OP_READ, '0, '0, 8'd5);
    push_req(OP_READ, '0, '0, 8'd7);
    push_req(OP_READ, '0, '0, 8'd8);
    push_req(OP_READ, '0, '0, 8'(7 + BUCKETS));
    push_req(OP_READ, '0, '0, 8'(8 + BUCKETS));
    push_req(OP_READ, '0, '0, 8'(9 + BUCKETS));
    push_req(OP_READ, '1, '1, 8'hFF);
    push_req(OP_CLEAR, '0, '0, '0);
    push_req(OP_READ, '0, '0, 8'd0);
    push_req(OP_READ, '0, '0, 8'(8 + BUCKETS));
    drain();

    run_phase(1'b0, 8'd128, 1'b1, 1'b1, 1'b0, MIX_CLEAR, 250);
    run_phase(1'b1, 8'd0, 1'b1, 1'b1, 1'b0, MIX_CLEAR, 250);
    run_phase(1'b1, 8'($urandom_range(1, 127)), 1'b0, 1'b0, 1'b1, MIX_KEEP, 200);
    run_phase(1'b0, 8'($urandom_range(1, 127)), 1'b1, 1'b1, 1'b0, SAMPLE_RUN, 650);
    run_phase(1'b1, 8'd128, 1'b1, 1'b1, 1'b0, MIX_CLEAR, 250);
    repeat (20) @(posedge clk);

    $display("covered %0d items, %0d results: %0d bad words, %0d alias hits, %0d samples",
             n_items, n_results, n_bad, n_hits, n_samples);
    $display("%0d register writes, %0d failed checks", n_writes, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
